FILE: src/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg: shared types and helpers for the 3D vector unit
// Fixed-point widths, action codes, stage payload structs, round and saturate.
// ----------------------------------------------------------------------------
package vau_pkg;

	localparam int W    = 32;          // word width
	localparam int F    = 16;          // fraction bits
	localparam int OPW  = W + 1;       // multiplier operand (holds a-b)
	localparam int PW   = 2 * OPW;     // product width
	localparam int SUMW = PW + 2;      // sum of three products
	localparam int RW   = OPW;         // square root width, one bit per stage
	localparam int REMW = PW + 2;      // square root remainder
	localparam int NUMW = W + F + 2;   // normalise dividend
	localparam int DW   = W + 1;       // normalise divisor (2 * length)
	localparam int QB   = W - 1;       // quotient bits below saturation
	localparam int CW   = DW + QB;     // divider compare width
	localparam int THRW = W - 1;       // threshold register width
	localparam int QDEPTH = 2;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);
	localparam int IN_DW  = 7 * W;
	localparam int OUT_DW = 4 * W;

	typedef logic signed [W-1:0]   word_t;
	typedef logic signed [OPW-1:0] opw_t;
	typedef logic [3:0]            act_t;

	localparam act_t ACT_ADD   = 4'd0;
	localparam act_t ACT_SUB   = 4'd1;
	localparam act_t ACT_MUL   = 4'd2;
	localparam act_t ACT_SCALE = 4'd3;
	localparam act_t ACT_DOT   = 4'd4;
	localparam act_t ACT_CROSS = 4'd5;
	localparam act_t ACT_LEN   = 4'd6;
	localparam act_t ACT_DIST  = 4'd7;
	localparam act_t ACT_NORM  = 4'd8;
	localparam act_t ACT_MID   = 4'd9;

	localparam word_t SMAX = {1'b0, {(W-1){1'b1}}};
	localparam word_t SMIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [SUMW-1:0] HALF = SUMW'(1) << (F - 1);

	// results and flags as known so far, carried down the pipeline
	typedef struct packed {
		act_t        act;
		word_t [2:0] a;
		word_t [2:0] rv;
		word_t       so;
		logic        ovf;
	} side_t;

	typedef struct packed {
		side_t       side;
		opw_t  [5:0] op_a;
		opw_t  [5:0] op_b;
	} front_item_t;

	typedef struct packed {
		side_t            side;
		logic [REMW-1:0]  rem;
		logic [RW-1:0]    r;
	} sq_t;

	typedef struct packed {
		side_t                 side;
		word_t                 len;
		logic                  lovf;
		logic                  scaled;
		logic [DW-1:0]         d;
		logic [2:0][NUMW-1:0]  rem;
		logic [2:0][QB-1:0]    q;
		logic [2:0]            dovf;
	} dv_t;

	typedef struct packed {
		word_t v;
		logic  o;
	} sat_t;

	function automatic sat_t sat_word(input logic signed [SUMW-1:0] x);
		sat_t s;
		s.o = !(&x[SUMW-1:W-1]) && (|x[SUMW-1:W-1]);
		s.v = s.o ? (x[SUMW-1] ? SMIN : SMAX) : x[W-1:0];
		return s;
	endfunction

	// round to nearest, ties up, then drop the fraction
	function automatic logic signed [SUMW-1:0] rnd_shift(input logic signed [SUMW-1:0] x);
		return (x + HALF) >>> F;
	endfunction

endpackage

FILE: src/vector3_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit: 3D vector arithmetic in signed Q16.16
// Add, sub, component mul, scale, dot, cross, length, distance, normalise,
// midpoint; saturating results with overflow flag.
// ----------------------------------------------------------------------------
//  channel          | dir | signals
//  -----------------+-----+------------------------------------------------
//  request in       | in  | s_tvalid/s_tready, s_tdata (224), s_tuser (4)
//  result out       | out | m_tvalid/m_tready, m_tdata (128), m_tuser (2)
//  threshold write  | in  | norm_threshold_we, norm_threshold_wdata (31)
//
//  One request per cycle sustained while results are taken; the pipeline has
//  71 register stages, among them the 33 square root stages and the 31
//  divider stages. Every request walks the full pipeline, so results leave in
//  order.
//  A 2-entry queue decouples intake from the arithmetic pipeline; the whole
//  pipeline holds while the output register carries an untaken result.
//  arst_n clears valid state and the threshold; no clearing pass.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// ax, ay, az, bx, by, bz, scale; 32 bits each from bit 0 up
	input  logic [vau_pkg::IN_DW-1:0]        s_tdata,
	// action
	input  logic [3:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// rx, ry, rz, scalar_out; 32 bits each from bit 0 up
	output logic [vau_pkg::OUT_DW-1:0]       m_tdata,
	// overflow, scaled
	output logic [1:0]                       m_tuser,
	input  logic                             norm_threshold_we,
	input  logic [vau_pkg::THRW-1:0]         norm_threshold_wdata
);

	logic [vau_pkg::THRW-1:0]  thr_q;
	logic                      f_valid;
	logic                      f_ready;
	vau_pkg::front_item_t      f_item;
	logic                      b_valid;
	logic                      b_ready;
	vau_pkg::front_item_t      b_item;

	// threshold register; write it only while the unit is idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (norm_threshold_we) begin
			thr_q <= norm_threshold_wdata;
		end
	end

	// intake: decode action, finish the cheap ops, route multiplier operands
	vau_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (f_valid),
		.item_ready (f_ready),
		.item       (f_item)
	);

	vau_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_item   (f_item),
		.out_valid (b_valid),
		.out_ready (b_ready),
		.out_item  (b_item)
	);

	// arithmetic: products, root, divider, output register
	vau_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (b_valid),
		.in_ready (b_ready),
		.in_item  (b_item),
		.thr      (thr_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: src/vau_front.sv
// ----------------------------------------------------------------------------
// vau_front: request intake and classification
// Decodes the action, finishes add/sub/midpoint, routes multiplier operands.
// ----------------------------------------------------------------------------
module vau_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [vau_pkg::IN_DW-1:0]     s_tdata,
	input  logic [3:0]                    s_tuser,
	output logic                          item_valid,
	input  logic                          item_ready,
	output vau_pkg::front_item_t          item
);

	vau_pkg::front_item_t it;
	vau_pkg::front_item_t f_q;
	logic                 f_v_q;
	vau_pkg::word_t       av [3];
	vau_pkg::word_t       bv [3];
	vau_pkg::word_t       sc;
	vau_pkg::opw_t        sm [3];
	vau_pkg::opw_t        df [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			av[i] = s_tdata[i*vau_pkg::W +: vau_pkg::W];
			bv[i] = s_tdata[(i+3)*vau_pkg::W +: vau_pkg::W];
		end
		sc = s_tdata[6*vau_pkg::W +: vau_pkg::W];
	end

	always_comb begin
		vau_pkg::sat_t st;
		it = '0;
		st = '0;
		it.side.act = s_tuser;
		for (int i = 0; i < 3; i++) begin
			it.side.a[i] = av[i];
			sm[i] = vau_pkg::OPW'(av[i]) + vau_pkg::OPW'(bv[i]);
			df[i] = vau_pkg::OPW'(av[i]) - vau_pkg::OPW'(bv[i]);
		end
		case (s_tuser)
			vau_pkg::ACT_ADD: begin
				for (int i = 0; i < 3; i++) begin
					st = vau_pkg::sat_word(vau_pkg::SUMW'(sm[i]));
					it.side.rv[i] = st.v;
					it.side.ovf   = it.side.ovf | st.o;
				end
			end
			vau_pkg::ACT_SUB: begin
				for (int i = 0; i < 3; i++) begin
					st = vau_pkg::sat_word(vau_pkg::SUMW'(df[i]));
					it.side.rv[i] = st.v;
					it.side.ovf   = it.side.ovf | st.o;
				end
			end
			vau_pkg::ACT_MID: begin
				// (a+b+1)>>1 always fits the word
				for (int i = 0; i < 3; i++)
					it.side.rv[i] = vau_pkg::W'((sm[i] + vau_pkg::opw_t'(1)) >>> 1);
			end
			vau_pkg::ACT_MUL, vau_pkg::ACT_DOT: begin
				for (int i = 0; i < 3; i++) begin
					it.op_a[i] = vau_pkg::OPW'(av[i]);
					it.op_b[i] = vau_pkg::OPW'(bv[i]);
				end
			end
			vau_pkg::ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					it.op_a[i] = vau_pkg::OPW'(av[i]);
					it.op_b[i] = vau_pkg::OPW'(sc);
				end
			end
			vau_pkg::ACT_CROSS: begin
				it.op_a[0] = vau_pkg::OPW'(av[1]); it.op_b[0] = vau_pkg::OPW'(bv[2]);
				it.op_a[1] = vau_pkg::OPW'(av[2]); it.op_b[1] = vau_pkg::OPW'(bv[1]);
				it.op_a[2] = vau_pkg::OPW'(av[2]); it.op_b[2] = vau_pkg::OPW'(bv[0]);
				it.op_a[3] = vau_pkg::OPW'(av[0]); it.op_b[3] = vau_pkg::OPW'(bv[2]);
				it.op_a[4] = vau_pkg::OPW'(av[0]); it.op_b[4] = vau_pkg::OPW'(bv[1]);
				it.op_a[5] = vau_pkg::OPW'(av[1]); it.op_b[5] = vau_pkg::OPW'(bv[0]);
			end
			vau_pkg::ACT_LEN, vau_pkg::ACT_NORM: begin
				for (int i = 0; i < 3; i++) begin
					it.op_a[i] = vau_pkg::OPW'(av[i]);
					it.op_b[i] = vau_pkg::OPW'(av[i]);
				end
			end
			vau_pkg::ACT_DIST: begin
				for (int i = 0; i < 3; i++) begin
					it.op_a[i] = df[i];
					it.op_b[i] = df[i];
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready   = !f_v_q || item_ready;
	assign item_valid = f_v_q;
	assign item       = f_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_q <= 1'b0;
		end else if (s_tready) begin
			f_v_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			f_q <= it;
		end
	end

	a_front_hold: assert property (@(posedge clk) disable iff (!arst_n)
		f_v_q && !item_ready |=> f_v_q)
		else $error("front stage dropped a request");

endmodule

FILE: src/vau_queue.sv
// ----------------------------------------------------------------------------
// vau_queue: small FIFO between front and back
// Lets the intake keep taking requests while the back end is stalled, until full.
// ----------------------------------------------------------------------------
module vau_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  vau_pkg::front_item_t  in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output vau_pkg::front_item_t  out_item
);

	vau_pkg::front_item_t       mem_q [vau_pkg::QDEPTH];
	logic [vau_pkg::QPW-1:0]    wr_q;
	logic [vau_pkg::QPW-1:0]    rd_q;
	logic [vau_pkg::QCW-1:0]    count_q;
	logic                       push;
	logic                       pop;

	assign in_ready  = count_q != vau_pkg::QCW'(vau_pkg::QDEPTH);
	assign out_valid = count_q != '0;
	assign out_item  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			count_q <= count_q + vau_pkg::QCW'(push) - vau_pkg::QCW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_item;
		end
	end

	a_q_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= vau_pkg::QCW'(vau_pkg::QDEPTH))
		else $error("queue count beyond depth");

endmodule

FILE: src/vau_back.sv
// ----------------------------------------------------------------------------
// vau_back: arithmetic pipeline
// Products, sums, bit-serial square root and divider stages, output register.
// ----------------------------------------------------------------------------
module vau_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  vau_pkg::front_item_t           in_item,
	input  logic [vau_pkg::THRW-1:0]       thr,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [vau_pkg::OUT_DW-1:0]     m_tdata,
	output logic [1:0]                     m_tuser
);

	logic                                  en;
	logic                                  v_s1;
	vau_pkg::side_t                        side_s1;
	logic signed [vau_pkg::PW-1:0]         p_s1 [6];
	vau_pkg::sq_t                          s2;
	vau_pkg::sq_t                          sq_q [vau_pkg::RW+1];
	logic                                  sq_v_q [vau_pkg::RW+1];
	logic [vau_pkg::RW:0]                  rr;
	logic                                  rt_v_s;
	vau_pkg::side_t                        rt_side_s;
	vau_pkg::word_t                        rt_len_s;
	logic                                  rt_lovf_s;
	vau_pkg::dv_t                          d0;
	vau_pkg::dv_t                          dv_q [vau_pkg::QB+1];
	logic                                  dv_v_q [vau_pkg::QB+1];
	vau_pkg::word_t [2:0]                  o_rv;
	vau_pkg::word_t                        o_so;
	logic                                  o_ovf;
	logic                                  o_scl;
	logic                                  m_tvalid_q;
	logic [vau_pkg::OUT_DW-1:0]            m_tdata_q;
	logic [1:0]                            m_tuser_q;

	// whole pipeline moves unless the output register holds an untaken result
	assign en       = !m_tvalid_q || m_tready;
	assign in_ready = en;

	// stage 1: six products
	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= in_item.side;
			for (int i = 0; i < 6; i++)
				p_s1[i] <= $signed(in_item.op_a[i]) * $signed(in_item.op_b[i]);
		end
	end

	// stage 2: round, sum, saturate; sum of squares for the root
	always_comb begin
		vau_pkg::sat_t st;
		logic signed [vau_pkg::SUMW-1:0] x;
		s2      = '0;
		st      = '0;
		s2.side = side_s1;
		x = vau_pkg::SUMW'(p_s1[0]) + vau_pkg::SUMW'(p_s1[1]) + vau_pkg::SUMW'(p_s1[2]);
		s2.rem  = vau_pkg::REMW'(x[vau_pkg::PW-1:0]);
		case (side_s1.act)
			vau_pkg::ACT_MUL, vau_pkg::ACT_SCALE: begin
				for (int i = 0; i < 3; i++) begin
					st = vau_pkg::sat_word(vau_pkg::rnd_shift(vau_pkg::SUMW'(p_s1[i])));
					s2.side.rv[i] = st.v;
					s2.side.ovf   = s2.side.ovf | st.o;
				end
			end
			vau_pkg::ACT_DOT: begin
				st = vau_pkg::sat_word(vau_pkg::rnd_shift(x));
				s2.side.so  = st.v;
				s2.side.ovf = st.o;
			end
			vau_pkg::ACT_CROSS: begin
				for (int i = 0; i < 3; i++) begin
					st = vau_pkg::sat_word(vau_pkg::rnd_shift(
						vau_pkg::SUMW'(p_s1[2*i]) - vau_pkg::SUMW'(p_s1[2*i+1])));
					s2.side.rv[i] = st.v;
					s2.side.ovf   = s2.side.ovf | st.o;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			sq_v_q[0] <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			sq_v_q[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) sq_q[0] <= s2;
	end

	// square root, one result bit per stage, MSB first
	for (genvar k = 0; k < vau_pkg::RW; k++) begin : g_sq
		localparam int B = vau_pkg::RW - 1 - k;
		logic [vau_pkg::REMW-1:0] trial;
		vau_pkg::sq_t             nx;
		assign trial = (vau_pkg::REMW'(sq_q[k].r) << (B + 1))
			+ (vau_pkg::REMW'(1) << (2 * B));

		always_comb begin
			nx = sq_q[k];
			if (trial <= sq_q[k].rem) begin
				nx.rem  = sq_q[k].rem - trial;
				nx.r[B] = 1'b1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_q[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_q[k+1] <= sq_v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) sq_q[k+1] <= nx;
		end
	end

	// round the root to nearest and saturate
	assign rr = {1'b0, sq_q[vau_pkg::RW].r}
		+ (vau_pkg::RW+1)'(sq_q[vau_pkg::RW].rem > vau_pkg::REMW'(sq_q[vau_pkg::RW].r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_v_s    <= 1'b0;
			dv_v_q[0] <= 1'b0;
		end else if (en) begin
			rt_v_s    <= sq_v_q[vau_pkg::RW];
			dv_v_q[0] <= rt_v_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_side_s <= sq_q[vau_pkg::RW].side;
			rt_lovf_s <= rr > (vau_pkg::RW+1)'(vau_pkg::SMAX);
			rt_len_s  <= (rr > (vau_pkg::RW+1)'(vau_pkg::SMAX)) ? vau_pkg::SMAX
				: rr[vau_pkg::W-1:0];
		end
	end

	// divider setup: |a|*2^(F+1)+L over 2L, early saturation test
	always_comb begin
		logic [vau_pkg::W-1:0] mag;
		d0        = '0;
		d0.side   = rt_side_s;
		d0.len    = rt_len_s;
		d0.lovf   = rt_lovf_s;
		d0.scaled = (rt_side_s.act == vau_pkg::ACT_NORM)
			&& (rt_len_s[vau_pkg::THRW-1:0] > thr);
		d0.d      = vau_pkg::DW'(unsigned'(rt_len_s)) << 1;
		for (int i = 0; i < 3; i++) begin
			mag = rt_side_s.a[i][vau_pkg::W-1] ? unsigned'(-rt_side_s.a[i])
				: unsigned'(rt_side_s.a[i]);
			d0.rem[i]  = (vau_pkg::NUMW'(mag) << (vau_pkg::F + 1))
				+ vau_pkg::NUMW'(unsigned'(rt_len_s));
			d0.dovf[i] = vau_pkg::CW'(d0.rem[i])
				>= (vau_pkg::CW'(unsigned'(rt_len_s)) << vau_pkg::W);
		end
	end

	always_ff @(posedge clk) begin
		if (en) dv_q[0] <= d0;
	end

	// restoring division, one quotient bit per stage in all three lanes
	for (genvar k = 0; k < vau_pkg::QB; k++) begin : g_dv
		localparam int B = vau_pkg::QB - 1 - k;
		logic [vau_pkg::CW-1:0] t;
		vau_pkg::dv_t           nx;
		assign t = vau_pkg::CW'(dv_q[k].d) << B;

		always_comb begin
			nx = dv_q[k];
			for (int i = 0; i < 3; i++) begin
				if (vau_pkg::CW'(dv_q[k].rem[i]) >= t) begin
					nx.rem[i]  = dv_q[k].rem[i] - vau_pkg::NUMW'(t);
					nx.q[i][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_q[k+1] <= 1'b0;
			end else if (en) begin
				dv_v_q[k+1] <= dv_v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) dv_q[k+1] <= nx;
		end
	end

	// final selection
	always_comb begin
		vau_pkg::word_t m;
		vau_pkg::dv_t   f;
		m     = '0;
		f     = dv_q[vau_pkg::QB];
		o_rv  = f.side.rv;
		o_so  = f.side.so;
		o_ovf = f.side.ovf;
		o_scl = 1'b0;
		case (f.side.act)
			vau_pkg::ACT_LEN, vau_pkg::ACT_DIST: begin
				o_so  = f.len;
				o_ovf = f.lovf;
			end
			vau_pkg::ACT_NORM: begin
				o_so  = f.len;
				o_ovf = f.lovf;
				o_scl = f.scaled;
				for (int i = 0; i < 3; i++) begin
					m = f.dovf[i] ? vau_pkg::SMAX : vau_pkg::word_t'({1'b0, f.q[i]});
					if (f.scaled) begin
						o_rv[i] = f.side.a[i][vau_pkg::W-1] ? -m : m;
						o_ovf   = o_ovf | f.dovf[i];
					end else begin
						o_rv[i] = f.side.a[i];
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dv_v_q[vau_pkg::QB];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= {o_so, o_rv[2], o_rv[1], o_rv[0]};
			m_tuser_q <= {o_scl, o_ovf};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	a_root_rem: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v_q[vau_pkg::RW] |-> sq_q[vau_pkg::RW].rem
			<= vau_pkg::REMW'({sq_q[vau_pkg::RW].r, 1'b0}))
		else $error("square root remainder out of range");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		dv_v_q[0] && dv_q[0].scaled |-> dv_q[0].d != '0)
		else $error("normalise scaling with zero length");

endmodule

FILE: test/vector3_arithmetic_unit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_checker: result predictor and scoreboard
// Watches requests and results, predicts each result and compares in order.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [vau_pkg::IN_DW-1:0]    s_tdata,
	input  logic [3:0]                   s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [vau_pkg::OUT_DW-1:0]   m_tdata,
	input  logic [1:0]                   m_tuser,
	input  logic                         norm_threshold_we,
	input  logic [vau_pkg::THRW-1:0]     norm_threshold_wdata,
	output int                           mismatches,
	output int                           pending
);

	typedef logic signed [127:0] wide_t;

	typedef struct packed {
		vau_pkg::word_t rx;
		vau_pkg::word_t ry;
		vau_pkg::word_t rz;
		vau_pkg::word_t so;
		logic           ovf;
		logic           scaled;
	} vec_result_t;

	vec_result_t expected_q[$];
	logic [vau_pkg::THRW-1:0] threshold;

	function automatic vau_pkg::word_t clamp_word(input wide_t x, inout logic ovf);
		if (x > wide_t'(vau_pkg::SMAX)) begin
			ovf = 1'b1;
			return vau_pkg::SMAX;
		end
		if (x < wide_t'(vau_pkg::SMIN)) begin
			ovf = 1'b1;
			return vau_pkg::SMIN;
		end
		return vau_pkg::word_t'(x);
	endfunction

	function automatic wide_t round_shift(input wide_t x, input int n);
		return (x + (wide_t'(1) <<< (n - 1))) >>> n;
	endfunction

	// rounded integer square root of x^2+y^2+z^2
	function automatic vau_pkg::word_t vec_length(input wide_t x, y, z, inout logic ovf);
		logic [127:0] s, t, rem;
		logic [63:0] r;
		s = x * x + y * y + z * z;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			t = {64'd0, r | (64'd1 << b)};
			if (t * t <= s)
				r = t[63:0];
		end
		rem = s - {64'd0, r} * {64'd0, r};
		if (rem > {64'd0, r})
			r++;
		if (r > 64'(vau_pkg::SMAX)) begin
			ovf = 1'b1;
			return vau_pkg::SMAX;
		end
		return vau_pkg::word_t'(r);
	endfunction

	// v / len in Q16.16, ties away from zero
	function automatic vau_pkg::word_t unit_component(input vau_pkg::word_t v,
			input vau_pkg::word_t len, inout logic ovf);
		logic [127:0] num, q;
		vau_pkg::word_t m;
		num = ((v < 0) ? 128'(-wide_t'(v)) : 128'(wide_t'(v))) << (vau_pkg::F + 1);
		num += 128'(len);
		q = num / (128'(len) << 1);
		if (q > 128'(vau_pkg::SMAX)) begin
			ovf = 1'b1;
			m = vau_pkg::SMAX;
		end else
			m = vau_pkg::word_t'(q);
		return (v < 0) ? -m : m;
	endfunction

	function automatic vec_result_t predict_vector_op(input vau_pkg::act_t act,
			input vau_pkg::word_t [6:0] f, input logic [vau_pkg::THRW-1:0] thr);
		vec_result_t r;
		wide_t a[3], b[3];
		wide_t sc;
		logic o;
		r = '0;
		o = 1'b0;
		for (int i = 0; i < 3; i++) begin
			a[i] = f[i];
			b[i] = f[i + 3];
		end
		sc = f[6];
		case (act)
			vau_pkg::ACT_ADD: begin
				r.rx = clamp_word(a[0] + b[0], o);
				r.ry = clamp_word(a[1] + b[1], o);
				r.rz = clamp_word(a[2] + b[2], o);
			end
			vau_pkg::ACT_SUB: begin
				r.rx = clamp_word(a[0] - b[0], o);
				r.ry = clamp_word(a[1] - b[1], o);
				r.rz = clamp_word(a[2] - b[2], o);
			end
			vau_pkg::ACT_MUL: begin
				r.rx = clamp_word(round_shift(a[0] * b[0], vau_pkg::F), o);
				r.ry = clamp_word(round_shift(a[1] * b[1], vau_pkg::F), o);
				r.rz = clamp_word(round_shift(a[2] * b[2], vau_pkg::F), o);
			end
			vau_pkg::ACT_SCALE: begin
				r.rx = clamp_word(round_shift(a[0] * sc, vau_pkg::F), o);
				r.ry = clamp_word(round_shift(a[1] * sc, vau_pkg::F), o);
				r.rz = clamp_word(round_shift(a[2] * sc, vau_pkg::F), o);
			end
			vau_pkg::ACT_DOT:
				r.so = clamp_word(round_shift(a[0] * b[0] + a[1] * b[1] + a[2] * b[2],
					vau_pkg::F), o);
			vau_pkg::ACT_CROSS: begin
				r.rx = clamp_word(round_shift(a[1] * b[2] - a[2] * b[1], vau_pkg::F), o);
				r.ry = clamp_word(round_shift(a[2] * b[0] - a[0] * b[2], vau_pkg::F), o);
				r.rz = clamp_word(round_shift(a[0] * b[1] - a[1] * b[0], vau_pkg::F), o);
			end
			vau_pkg::ACT_LEN:
				r.so = vec_length(a[0], a[1], a[2], o);
			vau_pkg::ACT_DIST:
				r.so = vec_length(a[0] - b[0], a[1] - b[1], a[2] - b[2], o);
			vau_pkg::ACT_NORM: begin
				r.so = vec_length(a[0], a[1], a[2], o);
				// scale only past the threshold; zero length never gets here
				if ($unsigned(r.so) > {1'b0, thr}) begin
					r.rx = unit_component(f[0], r.so, o);
					r.ry = unit_component(f[1], r.so, o);
					r.rz = unit_component(f[2], r.so, o);
					r.scaled = 1'b1;
				end else begin
					r.rx = f[0];
					r.ry = f[1];
					r.rz = f[2];
				end
			end
			vau_pkg::ACT_MID: begin
				r.rx = clamp_word(round_shift(a[0] + b[0], 1), o);
				r.ry = clamp_word(round_shift(a[1] + b[1], 1), o);
				r.rz = clamp_word(round_shift(a[2] + b[2], 1), o);
			end
			default: ;
		endcase
		r.ovf = o;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vec_result_t exp_r, got;
		if (!arst_n) begin
			threshold <= '0;
			mismatches <= 0;
			pending <= 0;
			expected_q.delete();
		end else begin
			if (norm_threshold_we)
				threshold <= norm_threshold_wdata;
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_vector_op(vau_pkg::act_t'(s_tuser), s_tdata,
					threshold));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96],
					m_tuser[0], m_tuser[1]};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result %h", $time, got);
					mismatches <= mismatches + 1;
				end else begin
					exp_r = expected_q.pop_front();
					if (got != exp_r) begin
						$display("%0t: mismatch expected rx %h ry %h rz %h so %h ovf %b scaled %b",
							$time, exp_r.rx, exp_r.ry, exp_r.rz, exp_r.so, exp_r.ovf,
							exp_r.scaled);
						$display("%0t:          actual rx %h ry %h rz %h so %h ovf %b scaled %b",
							$time, got.rx, got.ry, got.rz, got.so, got.ovf, got.scaled);
						mismatches <= mismatches + 1;
					end
				end
			end
			pending <= expected_q.size();
		end
	end

endmodule

FILE: test/vector3_arithmetic_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector3_arithmetic_unit_tb: stimulus and verdict for the 3D vector unit
// Directed corner requests, then random requests under several thresholds,
// with random stalls on both sides; the checker does the comparing.
// ----------------------------------------------------------------------------
module vector3_arithmetic_unit_tb;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [vau_pkg::IN_DW-1:0]    s_tdata = '0;   // ax, ay, az, bx, by, bz, scale
	logic [3:0]                   s_tuser = '0;   // action
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [vau_pkg::OUT_DW-1:0]   m_tdata;        // rx, ry, rz, scalar_out
	logic [1:0]                   m_tuser;        // overflow, scaled
	logic                         norm_threshold_we = 1'b0;
	logic [vau_pkg::THRW-1:0]     norm_threshold_wdata = '0;
	int                           mismatches, pending;
	logic                         no_idle = 1'b0;   // steady stretch, no gaps on either side

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	vector3_arithmetic_unit dut (.*);

	vector3_arithmetic_unit_checker checker_i (.*);

	// result side backpressure
	always @(posedge clk)
		m_tready <= no_idle || ($urandom_range(0, 99) >= 9);

	// a mix of full range, small magnitudes and extremes
	function automatic vau_pkg::word_t pick_word();
		case ($urandom_range(0, 5))
			0, 1: return vau_pkg::word_t'($urandom);
			2: return vau_pkg::word_t'($urandom_range(0, 1 << 21)) - (1 << 20);
			3: return vau_pkg::word_t'($signed($urandom)) >>> $urandom_range(0, 31);
			4: case ($urandom_range(0, 3))
				0: return vau_pkg::SMAX;
				1: return vau_pkg::SMIN;
				2: return '0;
				default: return -1;
			endcase
			default: return vau_pkg::word_t'($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	task automatic send_request(input vau_pkg::act_t act, input vau_pkg::word_t [6:0] f);
		if (!no_idle && $urandom_range(0, 99) < 9) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= f;
		s_tuser <= act;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random();
		vau_pkg::word_t [6:0] f;
		vau_pkg::act_t act;
		for (int i = 0; i < 7; i++)
			f[i] = pick_word();
		act = (($urandom_range(0, 19) == 0)) ? vau_pkg::act_t'($urandom_range(10, 15))
			: vau_pkg::act_t'($urandom_range(0, 9));
		send_request(act, f);
	endtask

	// drain the pipeline, then write the threshold while idle
	task automatic drain_and_set(input logic [vau_pkg::THRW-1:0] thr);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		norm_threshold_we <= 1'b1;
		norm_threshold_wdata <= thr;
		@(posedge clk);
		norm_threshold_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		vau_pkg::word_t [6:0] f;
		logic [vau_pkg::THRW-1:0] thr_list[4];
		thr_list = '{31'h7FFF_FFFF, 31'h0001_0000, 31'h0, 31'h0};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each action at the extremes, zero and unit vectors
		for (int a = 0; a < 10; a++) begin
			f = {vau_pkg::SMAX, vau_pkg::SMIN, vau_pkg::SMAX, vau_pkg::SMIN,
				vau_pkg::SMAX, vau_pkg::SMIN, vau_pkg::SMAX};
			send_request(vau_pkg::act_t'(a), f);
			f = {32'sh0001_0000, 32'sh0002_8000, -32'sh0000_8000, 32'sh0000_8000,
				32'sh0000_0000, -32'sh0003_0000, 32'sh0001_0000};
			send_request(vau_pkg::act_t'(a), f);
		end
		f = '0;
		send_request(vau_pkg::ACT_NORM, f);            // zero vector, never scaled
		f = '1;
		send_request(vau_pkg::ACT_LEN, f);
		send_request(vau_pkg::act_t'(15), f);          // unknown action
		send_request(vau_pkg::act_t'(10), {7{vau_pkg::SMIN}});

		for (int phase = 0; phase < 4; phase++) begin
			drain_and_set(phase == 3 ? vau_pkg::THRW'($urandom) : thr_list[phase]);
			for (int n = 0; n < 400; n++) begin
				no_idle <= (phase == 1 && n >= 100 && n < 300);
				send_random();
			end
		end
		s_tvalid <= 1'b0;
		no_idle <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5ms;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
